### hw/rtl/bole_pkg.sv
package bole_pkg;

    // Number of entries in the element store.
    localparam int Capacity = 64;
    localparam int AddrW = $clog2(Capacity);

    // Operation codes.
    localparam logic [3:0] FN_CREATE  = 4'd0;
    localparam logic [3:0] FN_DESTROY = 4'd1;
    localparam logic [3:0] FN_CLEAR   = 4'd2;
    localparam logic [3:0] FN_GET     = 4'd3;
    localparam logic [3:0] FN_LOCATE  = 4'd4;
    localparam logic [3:0] FN_PRIOR   = 4'd5;
    localparam logic [3:0] FN_NEXT    = 4'd6;
    localparam logic [3:0] FN_INSERT  = 4'd7;
    localparam logic [3:0] FN_DELETE  = 4'd8;
    localparam logic [3:0] FN_REVERSE = 4'd9;
    localparam logic [3:0] FN_NTH     = 4'd10;
    localparam logic [3:0] FN_SORT    = 4'd11;

    // Status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOLIST   = 3'd1;
    localparam logic [2:0] ST_BADPOS   = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_NONEIGH  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_EXISTS   = 3'd6;

    typedef struct packed {
        logic [3:0]  func;
        logic [7:0]  position;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic signed [31:0] result_value;
        logic [7:0]  result_index;
        logic [7:0]  list_length;
        logic        list_exists;
    } rsp_t;

endpackage

### hw/rtl/bole_if.sv
interface bole_req_if;
    logic          valid;
    logic          ready;
    bole_pkg::req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface bole_rsp_if;
    logic          valid;
    logic          ready;
    bole_pkg::rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/bounded_ordered_list_engine.sv
// Ordered list engine: one item in, one result out. The elements sit in a
// synchronous RAM of Capacity words with one write and one read port. Every
// walk reads an entry and uses it (or writes it) in the next cycle. Create,
// destroy, clear and every item refused at dispatch finish at dispatch; get
// and nth do a single read; locate, prior, next, insert, delete and reverse
// walk up to the whole list. Sort reads each pair, compares it and writes
// both entries back on a swap, in bubble passes, up to length passes. A
// result held by back-pressure stalls the engine in its done state. The
// input is ready only in the idle state, so a new item is accepted once the
// previous result has been moved into the output register, in the cycle
// after that load at the earliest.
module bounded_ordered_list_engine (
    input  logic clk,
    input  logic rst_n,
    bole_req_if.sink   in_ch,
    bole_rsp_if.source out_ch
);

    localparam int AW = bole_pkg::AddrW;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_RD, S_USE, S_SRCH, S_SRCH_USE,
        S_SHIFT_RD, S_SHIFT_WR, S_REV_RDJ, S_REV_WR, S_SORT_RD, S_SORT_CMP,
        S_DONE
    } state_t;

    // Element memory.
    logic [31:0] mem [bole_pkg::Capacity];
    logic [31:0] rdata_reg;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0] wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    state_t        state_reg, state_next;
    bole_pkg::req_t req_reg, req_next;
    logic [7:0]    len_reg, len_next;
    logic          ex_reg, ex_next;
    logic [7:0]    i_reg, i_next, j_reg, j_next;
    logic [31:0]   t_reg, t_next;
    logic          swp_reg, swp_next;
    logic [2:0]    st_reg, st_next;
    logic [31:0]   rv_reg, rv_next;
    logic [7:0]    ri_reg, ri_next;
    logic          ov_reg, ov_next;
    bole_pkg::rsp_t opay_reg, opay_next;

    assign in_ch.ready    = (state_reg == S_IDLE);
    assign out_ch.valid   = ov_reg;
    assign out_ch.payload = opay_reg;

    // Control sequencer.
    always_comb
    begin
        state_next = state_reg;
        req_next = req_reg;
        len_next = len_reg;
        ex_next = ex_reg;
        i_next = i_reg;
        j_next = j_reg;
        t_next = t_reg;
        swp_next = swp_reg;
        st_next = st_reg;
        rv_next = rv_reg;
        ri_next = ri_reg;
        ov_next = ov_reg;
        opay_next = opay_reg;
        we = 1'b0;
        waddr = i_reg[AW-1:0];
        wdata = t_reg;
        raddr = i_reg[AW-1:0];
        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    req_next = in_ch.payload;
                    st_next = bole_pkg::ST_OK;
                    rv_next = '0;
                    ri_next = '0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                if (req_reg.func == bole_pkg::FN_CREATE)
                begin
                    if (ex_reg)
                    begin
                        st_next = bole_pkg::ST_EXISTS;
                    end
                    else
                    begin
                        ex_next = 1'b1;
                        len_next = '0;
                    end
                end
                else if (req_reg.func <= bole_pkg::FN_SORT && !ex_reg)
                begin
                    st_next = bole_pkg::ST_NOLIST;
                end
                else
                begin
                    unique case (req_reg.func) inside
                        bole_pkg::FN_DESTROY:
                        begin
                            ex_next = 1'b0;
                            len_next = '0;
                        end
                        bole_pkg::FN_CLEAR: len_next = '0;
                        bole_pkg::FN_GET, bole_pkg::FN_NTH:
                        begin
                            if (req_reg.position == 8'd0 || req_reg.position > len_reg)
                            begin
                                st_next = bole_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                i_next = (req_reg.func == bole_pkg::FN_GET)
                                    ? req_reg.position - 8'd1
                                    : len_reg - req_reg.position;
                                state_next = S_RD;
                            end
                        end
                        bole_pkg::FN_LOCATE, bole_pkg::FN_PRIOR, bole_pkg::FN_NEXT:
                        begin
                            i_next = '0;
                            state_next = S_SRCH;
                        end
                        bole_pkg::FN_INSERT:
                        begin
                            if (len_reg >= 8'(bole_pkg::Capacity))
                            begin
                                st_next = bole_pkg::ST_FULL;
                            end
                            else if (req_reg.position == 8'd0
                                     || req_reg.position > len_reg + 8'd1)
                            begin
                                st_next = bole_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                // Shift up from the top: i is the destination.
                                i_next = len_reg;
                                state_next = S_SHIFT_RD;
                            end
                        end
                        bole_pkg::FN_DELETE:
                        begin
                            if (req_reg.position == 8'd0 || req_reg.position > len_reg)
                            begin
                                st_next = bole_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                i_next = req_reg.position - 8'd1;
                                state_next = S_RD;
                            end
                        end
                        bole_pkg::FN_REVERSE:
                        begin
                            if (len_reg > 8'd1)
                            begin
                                i_next = '0;
                                j_next = len_reg - 8'd1;
                                state_next = S_REV_RDJ;
                            end
                        end
                        bole_pkg::FN_SORT:
                        begin
                            if (len_reg > 8'd1)
                            begin
                                i_next = '0;
                                swp_next = 1'b0;
                                state_next = S_SORT_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // Single read for get, nth and the first step of delete.
            S_RD:
            begin
                raddr = i_reg[AW-1:0];
                state_next = S_USE;
            end
            S_USE:
            begin
                rv_next = rdata_reg;
                if (req_reg.func == bole_pkg::FN_DELETE)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            // Linear search for the first match.
            S_SRCH:
            begin
                if (i_reg >= len_reg)
                begin
                    st_next = bole_pkg::ST_NOTFOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    raddr = i_reg[AW-1:0];
                    state_next = S_SRCH_USE;
                end
            end
            S_SRCH_USE:
            begin
                if (t_reg == 32'd1)
                begin
                    // Neighbour read has come back.
                    rv_next = rdata_reg;
                    state_next = S_DONE;
                end
                else if (rdata_reg != req_reg.value)
                begin
                    i_next = i_reg + 8'd1;
                    state_next = S_SRCH;
                end
                else if (req_reg.func == bole_pkg::FN_LOCATE)
                begin
                    ri_next = i_reg + 8'd1;
                    rv_next = req_reg.value;
                    state_next = S_DONE;
                end
                else if (req_reg.func == bole_pkg::FN_PRIOR)
                begin
                    if (i_reg == 8'd0)
                    begin
                        st_next = bole_pkg::ST_NONEIGH;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        raddr = AW'(i_reg - 8'd1);
                        t_next = 32'd1;
                    end
                end
                else
                begin
                    if (i_reg + 8'd1 >= len_reg)
                    begin
                        st_next = bole_pkg::ST_NONEIGH;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        raddr = AW'(i_reg + 8'd1);
                        t_next = 32'd1;
                    end
                end
            end
            // Insert shifts down-to-up from the top; delete shifts up.
            S_SHIFT_RD:
            begin
                if (req_reg.func == bole_pkg::FN_INSERT)
                begin
                    if (i_reg < req_reg.position)
                    begin
                        we = 1'b1;
                        waddr = AW'(req_reg.position - 8'd1);
                        wdata = req_reg.value;
                        len_next = len_reg + 8'd1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        raddr = AW'(i_reg - 8'd1);
                        state_next = S_SHIFT_WR;
                    end
                end
                else
                begin
                    if (i_reg + 8'd1 >= len_reg)
                    begin
                        len_next = len_reg - 8'd1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        raddr = AW'(i_reg + 8'd1);
                        state_next = S_SHIFT_WR;
                    end
                end
            end
            S_SHIFT_WR:
            begin
                we = 1'b1;
                waddr = i_reg[AW-1:0];
                wdata = rdata_reg;
                i_next = (req_reg.func == bole_pkg::FN_INSERT) ? i_reg - 8'd1
                                                               : i_reg + 8'd1;
                state_next = S_SHIFT_RD;
            end
            // Reverse: read i, then read j while holding i, then two writes.
            S_REV_RDJ:
            begin
                if (i_reg >= j_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    raddr = i_reg[AW-1:0];
                    swp_next = 1'b0;
                    state_next = S_REV_WR;
                end
            end
            S_REV_WR:
            begin
                if (!swp_reg)
                begin
                    t_next = rdata_reg;
                    raddr = j_reg[AW-1:0];
                    swp_next = 1'b1;
                end
                else
                begin
                    // First write j with the saved i element, then i.
                    we = 1'b1;
                    waddr = j_reg[AW-1:0];
                    wdata = t_reg;
                    t_next = rdata_reg;
                    j_next = j_reg - 8'd1;
                    state_next = S_SORT_CMP;
                end
            end
            // Bubble pass: read i and i+1, compare, swap.
            S_SORT_RD:
            begin
                if (i_reg + 8'd1 >= len_reg)
                begin
                    if (swp_reg)
                    begin
                        i_next = '0;
                        swp_next = 1'b0;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    raddr = i_reg[AW-1:0];
                    ri_next = 8'd1;
                    state_next = S_SORT_CMP;
                end
            end
            S_SORT_CMP:
            begin
                if (req_reg.func == bole_pkg::FN_REVERSE)
                begin
                    // Second write of a reverse swap.
                    we = 1'b1;
                    waddr = i_reg[AW-1:0];
                    wdata = t_reg;
                    i_next = i_reg + 8'd1;
                    swp_next = 1'b0;
                    state_next = S_REV_RDJ;
                end
                else if (ri_reg == 8'd1)
                begin
                    t_next = rdata_reg;
                    raddr = AW'(i_reg + 8'd1);
                    ri_next = 8'd2;
                end
                else if (ri_reg == 8'd2)
                begin
                    if ($signed(t_reg) > $signed(rdata_reg))
                    begin
                        we = 1'b1;
                        waddr = i_reg[AW-1:0];
                        wdata = rdata_reg;
                        swp_next = 1'b1;
                        ri_next = 8'd3;
                    end
                    else
                    begin
                        i_next = i_reg + 8'd1;
                        state_next = S_SORT_RD;
                    end
                end
                else
                begin
                    we = 1'b1;
                    waddr = AW'(i_reg + 8'd1);
                    wdata = t_reg;
                    i_next = i_reg + 8'd1;
                    state_next = S_SORT_RD;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    opay_next.status = st_reg;
                    opay_next.result_value = rv_reg;
                    opay_next.result_index =
                        (req_reg.func == bole_pkg::FN_LOCATE) ? ri_reg : 8'd0;
                    opay_next.list_length = len_reg;
                    opay_next.list_exists = ex_reg;
                    ov_next = 1'b1;
                    t_next = '0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg <= '0;
            ex_reg <= 1'b0;
            ov_reg <= 1'b0;
            t_reg <= '0;
            opay_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg <= len_next;
            ex_reg <= ex_next;
            ov_reg <= ov_next;
            t_reg <= t_next;
            opay_reg <= opay_next;
        end
    end

    // Payload and walk registers.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        i_reg <= i_next;
        j_reg <= j_next;
        swp_reg <= swp_next;
        st_reg <= st_next;
        rv_reg <= rv_next;
        ri_reg <= ri_next;
    end

endmodule
